// ===== src/b64d_pkg.sv =====
package b64d_pkg;

    // Default width of the decoded-byte counter
    localparam int COUNT_BITS_DEF = 16;
    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;
    // Byte limit after reset
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    // Most results one character can cause
    localparam int JOB_BYTES = 3;

    // One job: the results caused by one accepted character
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0]  bytes;
        logic [JOB_BYTES-1:0][15:0] counts;
        logic [1:0]                 n;
        logic                       has_data;
        logic                       done;
        logic                       failed;
    } job_t;

endpackage

// ===== src/base64_decoder.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------------
// input     | in_valid / in_stall  | char_code
// output    | out_valid / out_stall| data_byte, has_data, done_res, failed, byte_count,
//           |                      | last
// config    | cfg_wr_en            | cfg_wr_data (byte limit)
//
// One character is taken per cycle while the job queue has room; a character
// that completes a group leaves a job of one to three results in the queue.
// The back end drains one result per cycle through its output register while
// out_stall is low, so the output port sets the rate. Reset clears the group
// state, the queue and the output register; the limit returns to 65535. A stall
// on either side only fills or drains the queue.
module base64_decoder #(
    parameter int COUNT_BITS  = b64d_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        done_res,
    output logic        failed,
    output logic [15:0] byte_count,
    output logic        last
);
    import b64d_pkg::*;

    logic [15:0] limit_reg;
    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        head_job;

    // Byte limit; the user must write it only while the decoder is idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    // Hold the input whenever the queue cannot take another job
    assign in_stall = queue_full;

    // Front end: classify each character, gather groups, apply the limit
    b64d_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .char_code  (char_code),
        .queue_full (queue_full),
        .limit      (limit_reg),
        .push       (push),
        .job        (push_job)
    );

    // Short queue decoupling the character side from the result side
    b64d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Back end: split each job into result transfers
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .empty      (queue_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .has_data   (has_data),
        .done_res   (done_res),
        .failed     (failed),
        .byte_count (byte_count),
        .last       (last)
    );

    // A job is never written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("job pushed into full queue");

    // The result that ends a text is always the last one of its character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> last)
        else $error("done result not marked last");

    // A failure is only reported together with the end of the text
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> (done_res && !has_data))
        else $error("failed without done or with data");

    // A result without data carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_data) |-> (data_byte == 8'd0))
        else $error("nonzero byte on result without data");

endmodule

// ===== src/b64d_front.sv =====
module b64d_front #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         char_code,
    input  logic               queue_full,
    input  logic [15:0]        limit,
    output logic               push,
    output b64d_pkg::job_t     job
);
    import b64d_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [7:0] CH_TERM    = 8'h00;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [6:0] NO_SEXTET  = 7'd64;

    // Map a character to its 6-bit value; NO_SEXTET when outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            s = 7'(c - CH_UPPER_A);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            s = 7'(c - 8'd71);
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            s = 7'(c + 8'd4);
        else if (c == CH_PLUS)
            s = 7'd62;
        else if (c == CH_SLASH)
            s = 7'd63;
        else
            s = NO_SEXTET;
        return s;
    endfunction

    logic [1:0]            pos_reg, pos_next;
    logic [17:0]           held_reg, held_next;
    logic                  third_pad_reg, third_pad_next;
    logic                  first_reg, first_next;
    logic                  skip_reg, skip_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  accept;
    logic                  gen;
    logic [6:0]            sext;
    logic                  is_pad;
    logic [5:0]            s4;
    logic [COUNT_BITS-1:0] cnt1, cnt2, cnt3;
    logic                  ok0, ok1, ok2;
    logic [1:0]            nbytes;
    logic [1:0]            emit;
    logic                  ended;

    assign accept = in_valid && !queue_full;
    assign push   = accept && gen;

    assign sext   = sextet_of(char_code);
    assign is_pad = (char_code == CH_PAD);
    assign s4     = is_pad ? 6'd0 : sext[5:0];

    assign cnt1 = count_reg + COUNT_BITS'(1);
    assign cnt2 = count_reg + COUNT_BITS'(2);
    assign cnt3 = count_reg + COUNT_BITS'(3);
    assign ok0  = CMP_W'(count_reg) < CMP_W'(limit);
    assign ok1  = CMP_W'(cnt1) < CMP_W'(limit);
    assign ok2  = CMP_W'(cnt2) < CMP_W'(limit);

    assign nbytes = third_pad_reg ? 2'd1 : (is_pad ? 2'd2 : 2'd3);

    always_comb
    begin
        // stop at the first due byte that would pass the limit
        if (!ok0)
            emit = 2'd0;
        else if (nbytes == 2'd1 || !ok1)
            emit = 2'd1;
        else if (nbytes == 2'd2 || !ok2)
            emit = 2'd2;
        else
            emit = 2'd3;
        ended = (emit != nbytes) || is_pad;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        first_next     = first_reg;
        skip_next      = skip_reg;
        count_next     = count_reg;
        gen            = 1'b0;

        // first byte of the group goes out first
        job.bytes[0] = {held_reg[17:12], held_reg[11:10]};
        job.bytes[1] = {held_reg[9:6], held_reg[5:2]};
        job.bytes[2] = {held_reg[1:0], s4};
        job.counts   = {16'(cnt3), 16'(cnt2), 16'(cnt1)};
        job.n        = 2'd1;
        job.has_data = 1'b0;
        job.done     = 1'b1;
        job.failed   = 1'b0;

        if (skip_reg) begin
            // drop everything up to and including the terminator
            if (char_code == CH_TERM)
                skip_next = 1'b0;
        end else if (char_code == CH_TERM) begin
            gen          = 1'b1;
            job.counts   = {16'd0, 16'd0, 16'(count_reg)};
            job.failed   = (pos_reg != 2'd0) || first_reg;
            pos_next       = 2'd0;
            held_next      = '0;
            third_pad_next = 1'b0;
            first_next     = 1'b1;
            count_next     = '0;
        end else if (!(sext != NO_SEXTET || (is_pad && pos_reg[1]))) begin
            gen          = 1'b1;
            job.counts   = {16'd0, 16'd0, 16'(count_reg)};
            job.failed   = 1'b1;
            pos_next       = 2'd0;
            held_next      = '0;
            third_pad_next = 1'b0;
            first_next     = 1'b1;
            count_next     = '0;
            skip_next      = 1'b1;
        end else if (pos_reg != 2'd3) begin
            if (pos_reg == 2'd2)
                third_pad_next = is_pad;
            held_next = {held_reg[11:0], s4};
            pos_next  = pos_reg + 2'd1;
        end else begin
            gen = 1'b1;
            pos_next       = 2'd0;
            held_next      = '0;
            third_pad_next = 1'b0;
            first_next     = 1'b0;
            if (emit == 2'd0) begin
                job.counts = {16'd0, 16'd0, 16'(count_reg)};
            end else begin
                job.n        = emit;
                job.has_data = 1'b1;
                job.done     = ended;
            end
            if (ended) begin
                first_next = 1'b1;
                count_next = '0;
                skip_next  = 1'b1;
            end else begin
                count_next = count_reg + COUNT_BITS'(emit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 2'd0;
            held_reg      <= '0;
            third_pad_reg <= 1'b0;
            first_reg     <= 1'b1;
            skip_reg      <= 1'b0;
            count_reg     <= '0;
        end else if (accept) begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            third_pad_reg <= third_pad_next;
            first_reg     <= first_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== src/b64d_queue.sv =====
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    input  logic           pop,
    output b64d_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

// ===== src/b64d_back.sv =====
module b64d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  b64d_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     data_byte,
    output logic           has_data,
    output logic           done_res,
    output logic           failed,
    output logic [15:0]    byte_count,
    output logic           last
);
    import b64d_pkg::*;

    logic        valid_reg;
    logic [7:0]  data_reg;
    logic        has_reg;
    logic        done_reg;
    logic        fail_reg;
    logic [15:0] count_reg;
    logic        last_reg;
    logic [1:0]  idx_reg;

    logic        advance;
    logic        load;
    logic        is_last;

    assign advance = !valid_reg || !out_stall;
    assign load    = advance && !empty;
    assign is_last = (idx_reg == head.n - 2'd1);
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (advance) begin
            valid_reg <= !empty;
            if (load)
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg  <= head.has_data ? head.bytes[idx_reg] : 8'd0;
            has_reg   <= head.has_data;
            done_reg  <= head.done && is_last;
            fail_reg  <= head.failed && is_last;
            count_reg <= head.counts[idx_reg];
            last_reg  <= is_last;
        end
    end

    assign out_valid  = valid_reg;
    assign data_byte  = data_reg;
    assign has_data   = has_reg;
    assign done_res   = done_reg;
    assign failed     = fail_reg;
    assign byte_count = count_reg;
    assign last       = last_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import b64d_pkg::*;

    localparam logic [7:0] TERM_CHAR    = 8'h00;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam int         NO_SEXTET    = 64;
    localparam int         RANDOM_ITEMS = 120;
    localparam int         NUM_PHASES   = 6;
    localparam int         MAX_REPORTS  = 10;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES  = 20;

    // One output transfer of the decoder
    typedef struct {
        logic [7:0]  data_byte;
        logic        has_data;
        logic        done_res;
        logic        failed;
        logic [15:0] byte_count;
        logic        last;
    } b64_result_t;

    // Decoder predictor plus the queue of bytes and outcomes still owed by the block.
    class b64_scoreboard;
        b64_result_t expected_q[$];
        int          mismatches;
        bit [15:0]   byte_limit;
        bit [1:0]    grp_pos;
        bit [17:0]   held;
        bit          third_pad;
        bit          first_grp;
        bit          skipping;
        bit [15:0]   decoded;

        function new();
            byte_limit = LIMIT_RESET;
            skipping   = 1'b0;
            mismatches = 0;
            restart_text();
        endfunction

        function void restart_text();
            grp_pos   = '0;
            held      = '0;
            third_pad = 1'b0;
            first_grp = 1'b1;
            decoded   = '0;
        endfunction

        function void set_limit(bit [15:0] value);
            byte_limit = value;
        endfunction

        function int sextet_value(logic [7:0] c);
            if (c >= "A" && c <= "Z") return c - "A";
            if (c >= "a" && c <= "z") return c - "a" + 26;
            if (c >= "0" && c <= "9") return c - "0" + 52;
            if (c == "+") return 62;
            if (c == "/") return 63;
            return NO_SEXTET;
        endfunction

        function b64_result_t make_result(logic [7:0] d, bit h, bit dn, bit f,
                                          bit [15:0] cnt);
            b64_result_t r;
            r.data_byte  = d;
            r.has_data   = h;
            r.done_res   = dn;
            r.failed     = f;
            r.byte_count = cnt;
            r.last       = 1'b0;
            return r;
        endfunction

        // Work out what one accepted character owes and queue it.
        function void note_char(logic [7:0] c);
            b64_result_t outs[3];
            logic [7:0]  trio[3];
            bit [5:0]    s1, s2, s3, s4;
            int          v, nbytes, n;
            bit          pad, ended, fail;

            if (skipping) begin
                if (c == TERM_CHAR)
                    skipping = 1'b0;
                return;
            end

            if (c == TERM_CHAR) begin
                fail = (grp_pos != 0) || first_grp;
                outs[0] = make_result(8'h00, 1'b0, 1'b1, fail, decoded);
                outs[0].last = 1'b1;
                expected_q.push_back(outs[0]);
                restart_text();
                return;
            end

            v   = sextet_value(c);
            pad = (c == PAD_CHAR);
            if (!(v < NO_SEXTET || (pad && grp_pos >= 2))) begin
                outs[0] = make_result(8'h00, 1'b0, 1'b1, 1'b1, decoded);
                outs[0].last = 1'b1;
                expected_q.push_back(outs[0]);
                restart_text();
                skipping = 1'b1;
                return;
            end
            if (pad)
                v = 0;

            // Hold the first three sextets of the group.
            if (grp_pos < 3) begin
                if (grp_pos == 2)
                    third_pad = pad;
                held    = {held[11:0], v[5:0]};
                grp_pos = grp_pos + 2'd1;
                return;
            end

            s1 = held[17:12];
            s2 = held[11:6];
            s3 = held[5:0];
            s4 = v[5:0];
            trio[0] = {s1, s2[5:4]};
            trio[1] = {s2[3:0], s3[5:2]};
            trio[2] = {s3[1:0], s4};
            nbytes  = third_pad ? 1 : (pad ? 2 : 3);

            n     = 0;
            ended = 1'b0;
            for (int i = 0; i < nbytes; i++) begin
                if (decoded >= byte_limit) begin
                    ended = 1'b1;
                    break;
                end
                decoded = decoded + 16'd1;
                outs[n] = make_result(trio[i], 1'b1, 1'b0, 1'b0, decoded);
                n++;
            end
            if (pad)
                ended = 1'b1;

            grp_pos   = '0;
            held      = '0;
            third_pad = 1'b0;
            first_grp = 1'b0;

            if (ended) begin
                if (n == 0) begin
                    outs[0] = make_result(8'h00, 1'b0, 1'b1, 1'b0, decoded);
                    n = 1;
                end else begin
                    outs[n-1].done_res = 1'b1;
                end
                restart_text();
                skipping = 1'b1;
            end
            outs[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_q.push_back(outs[i]);
        endfunction

        function void report(string what, b64_result_t want, b64_result_t got);
            if (mismatches < MAX_REPORTS) begin
                $write("%0t %s: expected byte=%02h has=%0b done=%0b fail=%0b cnt=%0d last=%0b",
                       $realtime, what,
                       want.data_byte, want.has_data, want.done_res, want.failed,
                       want.byte_count, want.last);
                $display(", got byte=%02h has=%0b done=%0b fail=%0b cnt=%0d last=%0b",
                         got.data_byte, got.has_data, got.done_res, got.failed,
                         got.byte_count, got.last);
            end
            mismatches++;
        endfunction

        function void check_result(b64_result_t got);
            b64_result_t want;
            bit          bad;

            if (expected_q.size() == 0) begin
                want = make_result(8'h00, 1'b0, 1'b0, 1'b0, 16'd0);
                report("unexpected result", want, got);
                return;
            end
            want = expected_q.pop_front();
            bad  = 1'b0;
            if (got.data_byte  !== want.data_byte)  bad = 1'b1;
            if (got.has_data   !== want.has_data)   bad = 1'b1;
            if (got.done_res   !== want.done_res)   bad = 1'b1;
            if (got.failed     !== want.failed)     bad = 1'b1;
            if (got.byte_count !== want.byte_count) bad = 1'b1;
            if (got.last       !== want.last)       bad = 1'b1;
            if (bad)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        done_res;
    logic        failed;
    logic [15:0] byte_count;
    logic        last;

    b64_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;

    base64_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .has_data    (has_data),
        .done_res    (done_res),
        .failed      (failed),
        .byte_count  (byte_count),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: stall at random per the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check every output transfer against the oldest owed result.
    always @(posedge clk)
    begin : watch_results
        b64_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.data_byte  = data_byte;
            got.has_data   = has_data;
            got.done_res   = done_res;
            got.failed     = failed;
            got.byte_count = byte_count;
            got.last       = last;
            sb.check_result(got);
        end
    end

    function automatic logic [7:0] char_of_sextet(int s);
        if (s < 26) return 8'("A" + s);
        if (s < 52) return 8'("a" + s - 26);
        if (s < 62) return 8'("0" + s - 52);
        if (s == 62) return "+";
        return "/";
    endfunction

    // Drive one character; return at the edge that takes the transfer.
    task automatic send_char(logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Hold off the sender until the block owes nothing.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the byte limit only with the block idle.
    task automatic write_byte_limit(logic [15:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // Mostly well-formed texts with random content; some noise, some broken groups.
    task automatic send_random_text();
        logic [7:0] txt[$];
        int         ngroups, style, pos, tail;

        ngroups = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        style   = $urandom_range(99);
        for (int g = 0; g < ngroups; g++) begin
            for (int k = 0; k < 4; k++)
                txt.push_back(char_of_sextet($urandom_range(63)));
            // pad in the third place, data in the fourth: one byte, keep going
            if (g < ngroups - 1 && $urandom_range(7) == 0)
                txt[txt.size() - 2] = PAD_CHAR;
        end
        tail = $urandom_range(3);
        if (tail == 0) begin
            txt[txt.size() - 2] = PAD_CHAR;
            txt[txt.size() - 1] = PAD_CHAR;
        end else if (tail == 1) begin
            txt[txt.size() - 1] = PAD_CHAR;
        end

        if (style < 15) begin
            pos = $urandom_range(txt.size() - 1);
            txt.insert(pos, 8'($urandom_range(255)));
        end else if (style < 25) begin
            repeat ($urandom_range(1, 3))
                void'(txt.pop_back());
        end else if (style < 32) begin
            repeat ($urandom_range(1, 3))
                txt.push_back(8'($urandom_range(1, 255)));
        end
        txt.push_back(TERM_CHAR);

        foreach (txt[i])
            send_char(txt[i]);
    endtask

    initial
    begin
        #2_000_000;
        $display("base64_decoder regression: fail");
        $finish;
    end

    initial
    begin : main_flow
        logic [15:0] limits[NUM_PHASES];
        int          phase_start;
        bit          paused;

        limits[0] = 16'd0;
        limits[1] = 16'd1;
        limits[2] = 16'd4;
        limits[3] = 16'($urandom_range(2, 12));
        limits[4] = 16'd7;
        limits[5] = 16'hFFFF;
        paused    = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts at the reset limit.
        send_char(TERM_CHAR);              // terminator with no group before it
        send_text("/+9z");                 // high sextets, three bytes
        send_char(TERM_CHAR);
        send_text("TQ==");                 // pad pair ends the text
        send_text("x");                    // skipped
        send_char(TERM_CHAR);
        send_text("ab=c");                 // third pad with fourth data
        send_text("A");
        send_char(TERM_CHAR);              // terminator inside a group
        send_char(8'h80);                  // code above 127
        send_char(TERM_CHAR);
        send_char(PAD_CHAR);               // pad in the first place
        send_char(TERM_CHAR);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_byte_limit(limits[p]);
            if (p < 2) begin
                send_idle_pct  = 36;
                recv_stall_pct = 45;
            end else if (p < 4) begin
                send_idle_pct  = 45;
                recv_stall_pct = 36;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            phase_start = chars_sent;
            while (chars_sent - phase_start < RANDOM_ITEMS / NUM_PHASES) begin
                send_random_text();
                if (p == 0 && !paused && chars_sent - phase_start >= 14) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("base64_decoder regression: pass");
        else
            $display("base64_decoder regression: fail");
        $finish;
    end

endmodule
